>>> src/sfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfpa_pkg;

  // fixed widths of the datapath
  localparam int DATA_BITS  = 18;
  localparam int GUARD_BITS = 4;
  localparam int MULT_BITS  = 18;

  // operand and result width, also the saturation width
  localparam int IN_W = DATA_BITS + GUARD_BITS;

  // multiply path
  localparam int MUL_DROP  = IN_W - MULT_BITS;
  localparam int PROD_W    = 2 * MULT_BITS;
  localparam int PROD_DROP = 2 * MULT_BITS - 22 - GUARD_BITS;

  // common pre-shift value width, wide enough for every path
  localparam int V_W = PROD_W - PROD_DROP;

  // add and subtract path
  localparam int ADD_W    = IN_W + 1;
  localparam int ADD_LIFT = 2;

  // seed paths
  localparam int SEED_SCALE    = 8;
  localparam int SEED_IN_DROP  = IN_W - 2 - SEED_SCALE;
  localparam int SEED_OUT_LIFT = DATA_BITS + 4 + GUARD_BITS - 3 - SEED_SCALE;
  localparam int U0_W          = IN_W - SEED_IN_DROP;
  localparam int SEED_W        = SEED_SCALE + 2;

  localparam logic [SEED_W-1:0] SEED_MID = SEED_W'(512);
  localparam logic [SEED_W-1:0] SEED_TOP = SEED_W'(1023);

  // saturation bounds
  localparam logic signed [IN_W-1:0] RES_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] RES_MIN = {1'b1, {(IN_W-1){1'b0}}};

  // final shift is by this value minus the selector
  localparam logic [1:0] SHIFT_BASE = 2'd3;

  // pipeline latency from request to result
  localparam int LATENCY = 4;

  typedef enum logic [2:0] {
    KIND_MUL   = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_RECIP = 3'd3,
    KIND_RSQRT = 3'd4
  } kind_t;

  // request to the seed generator
  typedef struct packed {
    logic [U0_W-1:0] u0;
    logic            is_rsqrt;
  } seed_req_t;

endpackage

`default_nettype wire

>>> src/saturating_fixed_point_alu.sv
// Saturating fixed-point ALU. One request is taken per clock whenever start is
// high and busy is low; busy is high only while rst_n is asserted. Every
// request gives exactly one result, marked by a one-cycle out_valid strobe, in
// request order. The four register stages are: operand preparation (sum,
// truncation, magnitude), the 18 x 18 multiplier and the seed generator, path
// selection and rescaling, then the final right shift by three minus the
// selector with saturation to 22 bits. The receiver cannot stall, so the
// result must be captured in the cycle out_valid is high.
// Unused operation codes give zero.
`timescale 1ns / 1ps
`default_nettype none

module saturating_fixed_point_alu (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire        [2:0]                  in_kind,
  input  wire signed [sfpa_pkg::IN_W-1:0]   in_operand_a,
  input  wire signed [sfpa_pkg::IN_W-1:0]   in_operand_b,
  input  wire        [1:0]                  in_shift_amount,
  output logic                              out_valid,
  output logic signed [sfpa_pkg::IN_W-1:0]  out_result
);
  import sfpa_pkg::*;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // stage 1: operand preparation
  logic                          s1_valid_r;
  kind_t                         s1_kind_r;
  logic [1:0]                    s1_sel_r;
  logic                          s1_neg_r;
  logic signed [MULT_BITS-1:0]   s1_mul_a_r;
  logic signed [MULT_BITS-1:0]   s1_mul_b_r;
  logic signed [ADD_W-1:0]       s1_addsub_r;
  logic [U0_W-1:0]               s1_u0_r;

  logic signed [ADD_W-1:0] addsub_nxt;
  logic [IN_W-1:0]         abs_a;

  always_comb begin
    if (in_kind == KIND_SUB) begin
      addsub_nxt = ADD_W'(in_operand_a) - ADD_W'(in_operand_b);
    end else begin
      addsub_nxt = ADD_W'(in_operand_a) + ADD_W'(in_operand_b);
    end
    abs_a = in_operand_a[IN_W-1] ? (~in_operand_a + 1'b1) : in_operand_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_kind_r   <= kind_t'(in_kind);
    s1_sel_r    <= in_shift_amount;
    s1_neg_r    <= in_operand_a[IN_W-1];
    s1_mul_a_r  <= in_operand_a[IN_W-1:MUL_DROP];
    s1_mul_b_r  <= in_operand_b[IN_W-1:MUL_DROP];
    s1_addsub_r <= addsub_nxt;
    s1_u0_r     <= abs_a[IN_W-1:SEED_IN_DROP];
  end

  // stage 2: multiplier and seed generator
  logic                       s2_valid_r;
  kind_t                      s2_kind_r;
  logic [1:0]                 s2_sel_r;
  logic                       s2_neg_r;
  logic signed [PROD_W-1:0]   s2_prod_r;
  logic signed [ADD_W-1:0]    s2_addsub_r;
  logic [SEED_W-1:0]          s2_seed_r;

  seed_req_t         seed_req;
  logic [SEED_W-1:0] seed_nxt;

  assign seed_req.u0       = s1_u0_r;
  assign seed_req.is_rsqrt = (s1_kind_r == KIND_RSQRT);

  sfpa_seed_gen u_seed (
    .req  (seed_req),
    .seed (seed_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_kind_r   <= s1_kind_r;
    s2_sel_r    <= s1_sel_r;
    s2_neg_r    <= s1_neg_r;
    s2_prod_r   <= s1_mul_a_r * s1_mul_b_r;
    s2_addsub_r <= s1_addsub_r;
    s2_seed_r   <= seed_nxt;
  end

  // stage 3: path selection and rescaling
  logic                  s3_valid_r;
  logic [1:0]            s3_sel_r;
  logic signed [V_W-1:0] s3_v_r;

  logic signed [V_W-1:0]    v_nxt;
  logic signed [SEED_W:0]   seed_signed;

  always_comb begin
    seed_signed = s2_neg_r ? -$signed({1'b0, s2_seed_r}) : $signed({1'b0, s2_seed_r});
    unique case (s2_kind_r)
      KIND_MUL:               v_nxt = V_W'(s2_prod_r >>> PROD_DROP);
      KIND_ADD, KIND_SUB:     v_nxt = V_W'(s2_addsub_r) <<< ADD_LIFT;
      KIND_RECIP, KIND_RSQRT: v_nxt = V_W'(seed_signed) <<< SEED_OUT_LIFT;
      default:                v_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_sel_r <= s2_sel_r;
    s3_v_r   <= v_nxt;
  end

  // stage 4: final shift and saturation
  logic signed [V_W-1:0]  v_sh;
  logic signed [IN_W-1:0] result_nxt;
  logic                   result_valid_r;
  logic signed [IN_W-1:0] result_r;

  always_comb begin
    v_sh = s3_v_r >>> (SHIFT_BASE - s3_sel_r);
    priority if (!v_sh[V_W-1] && (|v_sh[V_W-2:IN_W-1])) result_nxt = RES_MAX;
    else if (v_sh[V_W-1] && !(&v_sh[V_W-2:IN_W-1])) result_nxt = RES_MIN;
    else result_nxt = v_sh[IN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_valid_r <= 1'b0;
    end else begin
      result_valid_r <= s3_valid_r;
    end
    result_r <= result_nxt;
  end

  assign out_valid  = result_valid_r;
  assign out_result = result_r;

  // every result strobe follows an accepted request through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe does not follow request");

  // every request gives a result strobe once it has passed through the pipeline
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("request gave no result strobe");

  // unused operation codes give zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept, LATENCY) && ($past(in_kind, LATENCY) > 3'(KIND_RSQRT)))
    |-> (out_result == '0))
    else $error("unused operation gave a non-zero result");

  // zero reciprocal input with no post-shift saturates to the positive bound
  a_recip_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && (in_kind == KIND_RECIP) && (in_operand_a == '0)
      && (in_shift_amount == SHIFT_BASE), LATENCY))
    |-> (out_result == RES_MAX))
    else $error("reciprocal of zero did not saturate");

  // a multiply of two non-negative operands never goes negative
  a_mul_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && (in_kind == KIND_MUL) && !in_operand_a[IN_W-1]
      && !in_operand_b[IN_W-1], LATENCY))
    |-> !out_result[IN_W-1])
    else $error("product of non-negative operands is negative");

endmodule

`default_nettype wire

>>> src/sfpa_seed_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module sfpa_seed_gen (
  input  sfpa_pkg::seed_req_t         req,
  output logic [sfpa_pkg::SEED_W-1:0] seed
);
  import sfpa_pkg::*;

  logic [SEED_W-1:0] recip_s;
  logic [SEED_W-1:0] rsqrt_s;

  // reciprocal seed: leading-one position picks the power of two
  always_comb begin
    logic [3:0]        lead;
    logic [3:0]        k;
    logic [SEED_W-1:0] base;
    logic [SEED_W-1:0] mix;
    logic [U0_W-1:0]   u_sh;
    lead = 4'd0;
    for (int j = 0; j < U0_W; j++) begin
      if (req.u0[j]) lead = 4'(j + 1);
    end
    k    = (lead >= 4'd2) ? lead - 4'd2 : 4'd0;
    base = SEED_MID >> k;
    u_sh = req.u0 >> k;
    mix  = u_sh[0] ? base : base + (base >> 1);
    recip_s = mix >> 1;
    if (req.u0 < U0_W'(2)) recip_s = SEED_MID;
    if (req.u0 == '0) recip_s = SEED_TOP;
  end

  // inverse square root seed: two bits of input per halving of the seed
  always_comb begin
    logic [U0_W-1:0]   u;
    logic [SEED_W-1:0] s;
    logic [SEED_W+1:0] s3;
    u = req.u0;
    s = SEED_MID;
    for (int j = 0; j < 5; j++) begin
      if (u > U0_W'(7)) begin
        u = u >> 2;
        s = s >> 1;
      end
    end
    s3 = (SEED_W + 2)'(s) * (SEED_W + 2)'(3);
    priority if (u == U0_W'(2)) rsqrt_s = s + SEED_W'(s3 >> 2);
    else if (u == U0_W'(3)) rsqrt_s = s + (s >> 1);
    else if (u == U0_W'(4) || u == U0_W'(5)) rsqrt_s = s + (s >> 2);
    else rsqrt_s = s;
    if (req.u0 < U0_W'(2)) rsqrt_s = SEED_TOP;
  end

  assign seed = req.is_rsqrt ? rsqrt_s : recip_s;

endmodule

`default_nettype wire

>>> dv/saturating_fixed_point_alu_tb.sv
`timescale 1ns / 1ps

module saturating_fixed_point_alu_tb;
  import sfpa_pkg::*;

  // operation codes the block does not define, expected to give zero
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam int         CYCLE_LIMIT      = 400000;
  localparam int         RANDOM_REQS      = 1950;

  typedef struct {
    logic        [2:0]      kind;
    logic signed [IN_W-1:0] a;
    logic signed [IN_W-1:0] b;
    logic        [1:0]      sel;
    bit                     wait_drain;
  } alu_req_t;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   start           = 1'b0;
  logic        [2:0]      in_kind         = '0;
  logic signed [IN_W-1:0] in_operand_a    = '0;
  logic signed [IN_W-1:0] in_operand_b    = '0;
  logic        [1:0]      in_shift_amount = '0;
  wire                    busy;
  wire                    out_valid;
  wire  signed [IN_W-1:0] out_result;

  alu_req_t               pending_reqs[$];
  logic signed [IN_W-1:0] expected_results[$];
  logic signed [IN_W-1:0] want;
  bit                     req_accepted = 1'b0;
  int                     burst_left   = 1;
  int                     gap_left     = 0;
  int                     mismatches   = 0;
  int                     cycle_count  = 0;

  saturating_fixed_point_alu dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .in_shift_amount (in_shift_amount),
    .out_valid       (out_valid),
    .out_result      (out_result)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // coarse piecewise seed from |a|, sign of a restored
  function automatic longint seed_value(logic signed [IN_W-1:0] a, bit is_rsqrt);
    longint mag;
    longint u0;
    longint u;
    longint s;
    mag = (a < 0) ? -longint'(a) : longint'(a);
    u0  = mag >> SEED_IN_DROP;
    u   = u0;
    s   = longint'(SEED_MID);
    if (is_rsqrt) begin
      while (u > 7) begin
        u = u >> 2;
        s = s >> 1;
      end
      if (u == 2) s = s + 3 * s / 4;
      else if (u == 3) s = s + s / 2;
      else if (u == 4 || u == 5) s = s + s / 4;
      if (u0 < 2) s = longint'(SEED_TOP);
    end else begin
      while (u > 3) begin
        u = u >> 1;
        s = s >> 1;
      end
      if (u == 2) s = s + s / 2;
      s = s / 2;
      if (u0 < 2) s = longint'(SEED_MID);
      if (u0 == 0) s = longint'(SEED_TOP);
    end
    if (a < 0) s = -s;
    return s * (longint'(1) << SEED_OUT_LIFT);
  endfunction

  // expected result of one request
  function automatic logic signed [IN_W-1:0] alu_result(logic [2:0] kind,
                                                        logic signed [IN_W-1:0] a,
                                                        logic signed [IN_W-1:0] b,
                                                        logic [1:0] sel);
    longint v;
    case (kind)
      KIND_MUL: begin
        v = ((longint'(a) >>> MUL_DROP) * (longint'(b) >>> MUL_DROP)) >>> PROD_DROP;
      end
      KIND_ADD:   v = (longint'(a) + longint'(b)) * 4;
      KIND_SUB:   v = (longint'(a) - longint'(b)) * 4;
      KIND_RECIP: v = seed_value(a, 1'b0);
      KIND_RSQRT: v = seed_value(a, 1'b1);
      default:    return '0;
    endcase
    v = v >>> (SHIFT_BASE - sel);
    if (v > longint'(RES_MAX)) v = longint'(RES_MAX);
    if (v < longint'(RES_MIN)) v = longint'(RES_MIN);
    return IN_W'(v);
  endfunction

  // operand mix: extremes, small values, powers of two, full range
  function automatic logic signed [IN_W-1:0] pick_operand();
    logic signed [IN_W-1:0] v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = RES_MAX;
          1:       v = RES_MIN;
          2:       v = '0;
          3:       v = IN_W'(1);
          default: v = '1;
        endcase
      end
      1: v = IN_W'(int'($urandom_range(0, 255)) - 128);
      2: begin
        v = IN_W'(longint'(1) << $urandom_range(0, IN_W - 2));
        if ($urandom_range(0, 1)) v = v - IN_W'(1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = IN_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_req(logic [2:0] kind, logic signed [IN_W-1:0] a,
                         logic signed [IN_W-1:0] b, logic [1:0] sel, bit wait_drain = 1'b0);
    alu_req_t r;
    r.kind       = kind;
    r.a          = a;
    r.b          = b;
    r.sel        = sel;
    r.wait_drain = wait_drain;
    pending_reqs.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic signed [IN_W-1:0] got,
                                 logic signed [IN_W-1:0] exp_val);
    $display("mismatch at cycle %0d: %s, got %0d expected %0d",
             cycle_count, what, got, exp_val);
    mismatches++;
  endtask

  // driver: bursts of requests with random gaps, optional drain hold-off
  always @(negedge clk) begin
    if (req_accepted) pending_reqs.pop_front();
    if (!rst_n || pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start           <= 1'b0;
      in_kind         <= 3'($urandom);
      in_operand_a    <= IN_W'($urandom);
      in_operand_b    <= IN_W'($urandom);
      in_shift_amount <= 2'($urandom);
    end else if (pending_reqs[0].wait_drain && expected_results.size() != 0) begin
      start <= 1'b0;
    end else begin
      start           <= 1'b1;
      in_kind         <= pending_reqs[0].kind;
      in_operand_a    <= pending_reqs[0].a;
      in_operand_b    <= pending_reqs[0].b;
      in_shift_amount <= pending_reqs[0].sel;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // monitor: check results in order, then record the request taken this edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request waiting", out_result, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_result !== want) report_mismatch("out_result", out_result, want);
      end
    end
    req_accepted = rst_n && start && !busy;
    if (req_accepted) begin
      expected_results.push_back(alu_result(in_kind, in_operand_a, in_operand_b,
                                            in_shift_amount));
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    // multiply extremes, including rounding of negative products
    add_req(KIND_MUL, RES_MAX, RES_MAX, 2'd3);
    add_req(KIND_MUL, RES_MIN, RES_MIN, 2'd0);
    add_req(KIND_MUL, RES_MIN, RES_MAX, 2'd1);
    add_req(KIND_MUL, '0, RES_MIN, 2'd2);
    add_req(KIND_MUL, '1, '1, 2'd3);
    // add and subtract, saturating both ways
    add_req(KIND_ADD, RES_MAX, RES_MAX, 2'd3);
    add_req(KIND_ADD, RES_MIN, RES_MIN, 2'd2);
    add_req(KIND_SUB, RES_MAX, RES_MIN, 2'd0);
    add_req(KIND_SUB, RES_MIN, RES_MAX, 2'd3);
    add_req(KIND_ADD, '1, '0, 2'd0);
    // reciprocal seed: zero, tiny, most negative, large and mid inputs
    add_req(KIND_RECIP, '0, RES_MAX, 2'd3);
    add_req(KIND_RECIP, IN_W'(1), '0, 2'd0);
    add_req(KIND_RECIP, RES_MIN, RES_MIN, 2'd3);
    add_req(KIND_RECIP, RES_MAX, '1, 2'd2);
    add_req(KIND_RECIP, IN_W'(2 << SEED_IN_DROP), '0, 2'd1);
    add_req(KIND_RECIP, -IN_W'(3 << SEED_IN_DROP), '0, 2'd3);
    add_req(KIND_RECIP, IN_W'(5 << SEED_IN_DROP), IN_W'($urandom), 2'd3);
    // inverse square root seed across its pieces
    add_req(KIND_RSQRT, '0, '0, 2'd3);
    add_req(KIND_RSQRT, RES_MIN, RES_MAX, 2'd3);
    add_req(KIND_RSQRT, -IN_W'(2 << SEED_IN_DROP), '0, 2'd2);
    add_req(KIND_RSQRT, IN_W'(3 << SEED_IN_DROP), '0, 2'd3);
    add_req(KIND_RSQRT, IN_W'(4 << SEED_IN_DROP), '0, 2'd0);
    add_req(KIND_RSQRT, -IN_W'(5 << SEED_IN_DROP), '0, 2'd3);
    add_req(KIND_RSQRT, IN_W'(100 << SEED_IN_DROP), RES_MIN, 2'd1);
    // undefined operation codes
    for (int k = 0; k < 3; k++) begin
      add_req(KIND_SPARE_FIRST + 3'(k), RES_MAX, RES_MIN, 2'(k));
    end

    // random requests, mostly defined operations
    for (int i = 0; i < RANDOM_REQS; i++) begin
      logic [2:0] kind;
      if ($urandom_range(0, 15) == 0) kind = KIND_SPARE_FIRST + 3'($urandom_range(0, 2));
      else kind = 3'($urandom_range(KIND_MUL, KIND_RSQRT));
      add_req(kind, pick_operand(), pick_operand(), 2'($urandom),
              (i == 0) || (i == 600) || (i == 1400));
    end

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/sfpa_pkg.sv
src/sfpa_seed_gen.sv
src/saturating_fixed_point_alu.sv
dv/saturating_fixed_point_alu_tb.sv
